/* rtl/bcfe_pkg.sv */
// Shared types, constants and frame helpers for the command frame encoder.
`default_nettype none

package bcfe_pkg;

  localparam int unsigned FrameBytesMax = 5;
  localparam int unsigned ByteCntW      = 3;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam logic [7:0] HdrSingle  = 8'h90;
  localparam logic [7:0] HdrStackW  = 8'hB0;
  localparam logic [7:0] HdrBcastW  = 8'hD0;
  localparam logic [7:0] HdrBcastRv = 8'hE0;
  localparam logic [7:0] HdrStackRd = 8'hA0;

  typedef enum logic [2:0] {
    ActSingleWrite = 3'd0,
    ActStackWrite  = 3'd1,
    ActBcastWrite  = 3'd2,
    ActBcastRev    = 3'd3,
    ActStackRead   = 3'd4
  } bcfe_action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  device_id;
    logic [15:0] reg_addr;
    logic [7:0]  data_byte;
    logic [8:0]  read_length;
  } bcfe_cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } bcfe_out_t;

  // Payload bytes left-aligned, first byte to send in the top byte.
  typedef struct packed {
    logic [8*FrameBytesMax-1:0] payload;
    logic [ByteCntW-1:0]        nbytes;
  } bcfe_frame_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic bcfe_frame_t build_frame(input bcfe_cmd_t cmd);
    bcfe_frame_t f;
    logic [7:0]  tail;
    f.payload = '0;
    f.nbytes  = '0;
    tail = cmd.data_byte;
    case (cmd.action)
      ActSingleWrite: begin
        f.payload = {HdrSingle, cmd.device_id, cmd.reg_addr, tail};
        f.nbytes  = ByteCntW'(5);
      end
      ActStackWrite: begin
        f.payload = {HdrStackW, cmd.reg_addr, tail, 8'h00};
        f.nbytes  = ByteCntW'(4);
      end
      ActBcastWrite: begin
        f.payload = {HdrBcastW, cmd.reg_addr, tail, 8'h00};
        f.nbytes  = ByteCntW'(4);
      end
      ActBcastRev: begin
        f.payload = {HdrBcastRv, cmd.reg_addr, tail, 8'h00};
        f.nbytes  = ByteCntW'(4);
      end
      ActStackRead: begin
        // The length goes out as count minus one, wrapping a zero count to 0xFF.
        tail      = cmd.read_length[7:0] - 8'd1;
        f.payload = {HdrStackRd, cmd.reg_addr, tail, 8'h00};
        f.nbytes  = ByteCntW'(4);
      end
      default: begin
        f.payload = '0;
        f.nbytes  = '0;
      end
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

/* rtl/bcfe_serializer.sv */
// Byte serializer with running CRC-16 and an output register.
`default_nettype none

module bcfe_serializer
  import bcfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_valid_i,
  input  wire bcfe_frame_t frame_i,
  output logic             load_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output bcfe_out_t        out_data_o
);

  logic [8*FrameBytesMax-1:0] sr_q, sr_d;
  logic [ByteCntW-1:0]        pay_q, pay_d;
  logic [1:0]                 crc_left_q, crc_left_d;
  logic [15:0]                crc_q, crc_d;
  logic                       out_valid_q, out_valid_d;
  bcfe_out_t                  out_q, out_d;
  logic                       advance;
  logic                       idle;
  logic                       final_step;

  assign idle       = (pay_q == '0) && (crc_left_q == 2'd0);
  assign advance    = !out_valid_q || !out_stall_i;
  assign final_step = advance && (pay_q == '0) && (crc_left_q == 2'd1);
  // A new frame loads while the previous CRC high byte moves out.
  assign load_ready_o = idle || final_step;

  always_comb begin
    sr_d        = sr_q;
    pay_d       = pay_q;
    crc_left_d  = crc_left_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (advance) begin
      if (pay_q != '0) begin
        out_d.tx_byte   = sr_q[8*FrameBytesMax-1 -: 8];
        out_d.last_byte = 1'b0;
        sr_d            = {sr_q[8*FrameBytesMax-9:0], 8'h00};
        crc_d           = crc_byte(crc_q, sr_q[8*FrameBytesMax-1 -: 8]);
        pay_d           = pay_q - ByteCntW'(1);
        out_valid_d     = 1'b1;
      end else if (crc_left_q == 2'd2) begin
        out_d.tx_byte   = crc_q[7:0];
        out_d.last_byte = 1'b0;
        crc_left_d      = 2'd1;
        out_valid_d     = 1'b1;
      end else if (crc_left_q == 2'd1) begin
        out_d.tx_byte   = crc_q[15:8];
        out_d.last_byte = 1'b1;
        crc_left_d      = 2'd0;
        out_valid_d     = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end

    if (load_valid_i && load_ready_o) begin
      sr_d       = frame_i.payload;
      pay_d      = frame_i.nbytes;
      crc_d      = CrcInit;
      crc_left_d = (frame_i.nbytes != '0) ? 2'd2 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pay_q       <= '0;
      crc_left_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      pay_q       <= pay_d;
      crc_left_q  <= crc_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q  <= sr_d;
    crc_q <= crc_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/bms_command_frame_encoder_core.sv */
// Top level of the command frame encoder: command register and frame serializer.
//
// Usage: a command item enters on in_valid_i/in_stall_o with in_data_i and
// leaves as a frame of bytes on out_valid_o/out_stall_i with out_data_o,
// one byte per item, last_byte marking the CRC high byte that ends a frame.
// Single-device writes give 7 bytes, other commands 6; unused action codes
// are taken and give no bytes.
// Path: for a command taken into an idle block, the first byte passes from
// the command register through the serializer's shift register to its
// output register. Throughput: one byte per cycle while out_stall_i is low;
// a command is held in the command register while the previous frame drains,
// and loads as its last byte moves out, so frames follow without gaps.
// Stall: while out_stall_i is high the output byte holds; once the command
// register is full and cannot load, in_stall_o rises.
// Reset: asynchronous, clears the command register and any partly sent
// frame; no clearing pass is needed.
`default_nettype none

module bms_command_frame_encoder_core
  import bcfe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire bcfe_cmd_t in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output bcfe_out_t      out_data_o
);

  logic        cmd_valid_q, cmd_valid_d;
  bcfe_cmd_t   cmd_q;
  bcfe_frame_t frame;
  logic        load_ready;
  logic        accept;

  assign in_stall_o = cmd_valid_q && !load_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign frame      = build_frame(cmd_q);

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (accept) begin
      cmd_valid_d = 1'b1;
    end else if (cmd_valid_q && load_ready) begin
      cmd_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_data_i;
    end
  end

  bcfe_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (cmd_valid_q),
    .frame_i      (frame),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/bcfe_checker.sv */
// Port-level checker for the command frame encoder, bound to the top level.
`default_nettype none

module bcfe_checker
  import bcfe_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire bcfe_out_t out_data_o
);

  logic [2:0] idx_q;
  logic       out_take;

  assign out_take = out_valid_o && !out_stall_i;

  // Position of the next output item within its frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (out_take) begin
      idx_q <= out_data_o.last_byte ? 3'd0 : idx_q + 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && idx_q == 3'd0 |->
      out_data_o.tx_byte == HdrSingle || out_data_o.tx_byte == HdrStackW ||
      out_data_o.tx_byte == HdrBcastW || out_data_o.tx_byte == HdrBcastRv ||
      out_data_o.tx_byte == HdrStackRd)
    else $error("frame does not open with a header byte");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_data_o.last_byte |-> idx_q == 3'd5 || idx_q == 3'd6)
    else $error("frame length is not 6 or 7 bytes");

  a_frame_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && idx_q == 3'd6 |-> out_data_o.last_byte)
    else $error("frame runs past 7 bytes");

  // A frame that has just loaded shows its first byte in the next cycle.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_valid_o |=> out_valid_o)
    else $error("input stalled while no output item is on its way");

endmodule

bind bms_command_frame_encoder_core bcfe_checker u_bcfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the command frame encoder with a frame-byte scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import bcfe_pkg::*;

  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldoffCycles = 300;
  localparam int unsigned SettleCycles  = 20;

  // Action codes that the block takes without sending a frame.
  localparam logic [2:0] ActSpare5 = 3'd5;
  localparam logic [2:0] ActSpare6 = 3'd6;
  localparam logic [2:0] ActSpare7 = 3'd7;

  class frame_scoreboard;
    bcfe_out_t expected_bytes[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    task report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    static function logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      repeat (8) begin
        acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
      end
      return acc;
    endfunction

    // Builds the frame that one accepted command must produce.
    function void note_command(input bcfe_cmd_t cmd);
      logic [7:0]  frame[$];
      logic [7:0]  tail;
      logic [15:0] crc;
      bcfe_out_t   item;
      case (cmd.action)
        ActSingleWrite: begin
          frame.push_back(HdrSingle);
          frame.push_back(cmd.device_id);
        end
        ActStackWrite: frame.push_back(HdrStackW);
        ActBcastWrite: frame.push_back(HdrBcastW);
        ActBcastRev:   frame.push_back(HdrBcastRv);
        ActStackRead:  frame.push_back(HdrStackRd);
        default:       return;
      endcase
      // A read sends its length minus one; a zero length wraps to 0xFF.
      tail = (cmd.action == ActStackRead) ? 8'(cmd.read_length - 9'd1) : cmd.data_byte;
      frame.push_back(cmd.reg_addr[15:8]);
      frame.push_back(cmd.reg_addr[7:0]);
      frame.push_back(tail);
      crc = CrcInit;
      foreach (frame[i]) crc = crc16_update(crc, frame[i]);
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      foreach (frame[i]) begin
        item.tx_byte   = frame[i];
        item.last_byte = (i == frame.size() - 1);
        expected_bytes.push_back(item);
      end
    endfunction

    task check_byte(input bcfe_out_t got);
      bcfe_out_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte 0x%02h last=%0b", got.tx_byte,
                                  got.last_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.tx_byte !== want.tx_byte)
        report_mismatch($sformatf("tx_byte 0x%02h, expected 0x%02h", got.tx_byte,
                                  want.tx_byte));
      if (got.last_byte !== want.last_byte)
        report_mismatch($sformatf("last_byte %0b, expected %0b on byte 0x%02h",
                                  got.last_byte, want.last_byte, want.tx_byte));
    endtask
  endclass

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      cmd_valid  = 1'b0;
  logic      cmd_stall;
  bcfe_cmd_t cmd_data   = '0;
  logic      byte_valid;
  logic      byte_stall = 1'b0;
  bcfe_out_t byte_data;

  frame_scoreboard sb = new();

  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned holdoff_reqs   = 0;
  int unsigned holdoff_served = 0;
  int unsigned holdoff_left   = 0;
  int unsigned quiet_cycles   = 0;

  bms_command_frame_encoder_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (cmd_valid),
    .in_stall_o  (cmd_stall),
    .in_data_i   (cmd_data),
    .out_valid_o (byte_valid),
    .out_stall_i (byte_stall),
    .out_data_o  (byte_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      byte_stall <= 1'b1;
      holdoff_left--;
    end else if (holdoff_reqs != holdoff_served) begin
      holdoff_served++;
      holdoff_left = HoldoffCycles - 1;
      byte_stall <= 1'b1;
    end else begin
      byte_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && byte_valid && !byte_stall) sb.check_byte(byte_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (cmd_valid && !cmd_stall) || (byte_valid && !byte_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("ERROR %0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic bcfe_cmd_t make_cmd(input logic [2:0] action, input logic [7:0] dev,
                                         input logic [15:0] addr, input logic [7:0] dat,
                                         input logic [8:0] len);
    bcfe_cmd_t c;
    c.action      = action;
    c.device_id   = dev;
    c.reg_addr    = addr;
    c.data_byte   = dat;
    c.read_length = len;
    return c;
  endfunction

  function automatic bcfe_cmd_t random_cmd();
    bcfe_cmd_t c;
    int unsigned pick;
    c.action    = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
    c.device_id = 8'($urandom);
    c.reg_addr  = 16'($urandom);
    c.data_byte = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 80)      c.read_length = 9'($urandom_range(256, 1));
    else if (pick < 92) c.read_length = 9'($urandom_range(511, 0));
    else                c.read_length = (pick < 96) ? 9'd256 : 9'd0;
    return c;
  endfunction

  // Entered and left at a falling edge; valid stays high on exit.
  task send_command(input bcfe_cmd_t cmd);
    if ($urandom_range(99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= cmd;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_command(cmd);
    @(negedge clk);
  endtask

  task wait_for_frames();
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task run_random(input int unsigned count, input int unsigned tx_pct,
                  input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_command(random_cmd());
    wait_for_frames();
  endtask

  initial begin
    bcfe_cmd_t directed[$];
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed.push_back(make_cmd(ActSingleWrite, 8'h00, 16'h0000, 8'h00, 9'd0));
    directed.push_back(make_cmd(ActSingleWrite, 8'hFF, 16'hFFFF, 8'hFF, 9'h1FF));
    directed.push_back(make_cmd(ActSingleWrite, 8'hA5, 16'h1234, 8'h5A, 9'd17));
    directed.push_back(make_cmd(ActStackWrite, 8'hFF, 16'h0000, 8'hFF, 9'd0));
    directed.push_back(make_cmd(ActStackWrite, 8'h00, 16'hFFFF, 8'h00, 9'h1FF));
    directed.push_back(make_cmd(ActBcastWrite, 8'h3C, 16'h0000, 8'h00, 9'd256));
    directed.push_back(make_cmd(ActBcastWrite, 8'hC3, 16'hFFFF, 8'hFF, 9'd1));
    directed.push_back(make_cmd(ActBcastRev, 8'h00, 16'h8001, 8'h80, 9'd0));
    directed.push_back(make_cmd(ActBcastRev, 8'hFF, 16'h7FFE, 8'h7F, 9'd300));
    directed.push_back(make_cmd(ActStackRead, 8'hFF, 16'h0000, 8'hFF, 9'd1));
    directed.push_back(make_cmd(ActStackRead, 8'h00, 16'hFFFF, 8'h00, 9'd256));
    // A zero read length wraps to the same length byte as 256.
    directed.push_back(make_cmd(ActStackRead, 8'h12, 16'h0102, 8'hAA, 9'd0));
    directed.push_back(make_cmd(ActStackRead, 8'h34, 16'hFF00, 8'h55, 9'h1FF));
    directed.push_back(make_cmd(ActStackRead, 8'h56, 16'h00FF, 8'h01, 9'd2));
    directed.push_back(make_cmd(ActSpare5, 8'hFF, 16'hFFFF, 8'hFF, 9'h1FF));
    directed.push_back(make_cmd(ActSingleWrite, 8'h01, 16'h4000, 8'h02, 9'd5));
    directed.push_back(make_cmd(ActSpare6, 8'h00, 16'h0000, 8'h00, 9'd0));
    directed.push_back(make_cmd(ActSpare7, 8'h5A, 16'hA5A5, 8'h5A, 9'd128));
    directed.push_back(make_cmd(ActStackRead, 8'h00, 16'h2000, 8'h00, 9'd128));
    directed.push_back(make_cmd(ActSpare7, 8'hFF, 16'hFFFF, 8'hFF, 9'h1FF));
    directed.push_back(make_cmd(ActBcastWrite, 8'h00, 16'h0001, 8'h01, 9'd0));
    foreach (directed[i]) send_command(directed[i]);
    wait_for_frames();

    run_random(100, 0, 0);
    run_random(100, 53, 0);
    run_random(100, 0, 53);
    run_random(100, 10, 10);

    // The receiver holds off while commands keep coming, so the block fills up.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    holdoff_reqs++;
    repeat (50) send_command(random_cmd());
    wait_for_frames();
    run_random(50, 30, 30);

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* bms_command_frame_encoder_core.f */
rtl/bcfe_pkg.sv
rtl/bcfe_serializer.sv
rtl/bms_command_frame_encoder_core.sv
rtl/bcfe_checker.sv
sim/tb_top.sv
